[hdl/ipid_pkg.sv]
package ipid_pkg;

  // value format
  localparam int VW = 32;            // value width, two's complement
  localparam int FB = 16;            // fraction bits

  // arithmetic widths
  localparam int BW = VW + 2;        // magnitude width of the widest multiplier operand
  localparam int PL = (BW + 1) / 2;  // low slice of the split operand
  localparam int PH = BW - PL;       // high slice of the split operand
  localparam int MW = VW + BW;       // full unsigned product width
  localparam int QW = MW + 1 - FB;   // rounded product width before saturation
  localparam int TW = VW + 2;        // saturated term, +-(2^(VW+1)-1)
  localparam int SW = VW + 4;        // sum of three terms

  // product lanes
  localparam int NTERM  = 3;
  localparam int TERM_P = 0;
  localparam int TERM_I = 1;
  localparam int TERM_D = 2;

  // back pipeline depth ahead of the output register
  localparam int NSTAGE = 8;

  // queue between front and back
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  // configuration port
  localparam int CFG_IDX_W = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KP         = CFG_IDX_W'(0),
    REG_KI_DT      = CFG_IDX_W'(1),
    REG_KD_PER_DT  = CFG_IDX_W'(2),
    REG_OUT_LOW    = CFG_IDX_W'(3),
    REG_OUT_HIGH   = CFG_IDX_W'(4),
    REG_SEP_THRESH = CFG_IDX_W'(5),
    REG_STEP_LIMIT = CFG_IDX_W'(6),
    REG_RUN_ENABLE = CFG_IDX_W'(7)
  } reg_idx_e;

  typedef struct packed {
    logic signed [VW-1:0] kp;
    logic signed [VW-1:0] ki_dt;
    logic signed [VW-1:0] kd_per_dt;
    logic signed [VW-1:0] out_low;
    logic signed [VW-1:0] out_high;
    logic        [VW-2:0] sep_thresh;
    logic        [VW-2:0] step_limit;
    logic                 run_enable;
  } cfg_t;

  // one classified sample on its way from front to back
  typedef struct packed {
    logic                 hold;
    logic signed [VW-1:0] e;
    logic signed [VW-1:0] e1;
    logic signed [VW-1:0] e2;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

[hdl/ipid_queue.sv]
module ipid_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_en_i,
  input  ipid_pkg::item_t   wr_item_i,
  input  logic              rd_en_i,
  output ipid_pkg::item_t   rd_item_o,
  output ipid_pkg::q_stat_t stat_o
);

  ipid_pkg::item_t              mem_q [ipid_pkg::QDEPTH];
  logic [ipid_pkg::QAW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [ipid_pkg::QAW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [ipid_pkg::QAW:0]       count_q, count_d;

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (wr_en_i) begin
      wr_ptr_d = wr_ptr_q + ipid_pkg::QAW'(1);
    end
    if (rd_en_i) begin
      rd_ptr_d = rd_ptr_q + ipid_pkg::QAW'(1);
    end
    if (wr_en_i && !rd_en_i) begin
      count_d = count_q + (ipid_pkg::QAW+1)'(1);
    end else if (!wr_en_i && rd_en_i) begin
      count_d = count_q - (ipid_pkg::QAW+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_ptr_q] <= wr_item_i;
    end
  end

  assign rd_item_o    = mem_q[rd_ptr_q];
  assign stat_o.full  = (count_q == (ipid_pkg::QAW+1)'(ipid_pkg::QDEPTH));
  assign stat_o.empty = (count_q == '0);

endmodule

[hdl/ipid_front.sv]
module ipid_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ipid_pkg::cfg_t    cfg_i,
  input  logic              s_tvalid_i,
  output logic              s_tready_o,
  input  logic signed [ipid_pkg::VW-1:0] setpoint_i,
  input  logic signed [ipid_pkg::VW-1:0] measured_value_i,
  input  ipid_pkg::q_stat_t q_stat_i,
  output logic              push_o,
  output ipid_pkg::item_t   item_o
);

  logic                            fr_valid_q, fr_valid_d;
  logic signed [ipid_pkg::VW-1:0]  sp_q, mv_q;
  logic signed [ipid_pkg::VW-1:0]  e1_q, e2_q;
  logic signed [ipid_pkg::VW:0]    diff;
  logic signed [ipid_pkg::VW-1:0]  e_sat;
  logic                            accept;

  // handshake: the front register empties into the queue
  assign push_o     = fr_valid_q && !q_stat_i.full;
  assign s_tready_o = !fr_valid_q || push_o;
  assign accept     = s_tvalid_i && s_tready_o;

  always_comb begin
    fr_valid_d = fr_valid_q;
    if (accept) begin
      fr_valid_d = 1'b1;
    end else if (push_o) begin
      fr_valid_d = 1'b0;
    end
  end

  // error, saturated to the value range
  always_comb begin
    diff = (ipid_pkg::VW+1)'(sp_q) - (ipid_pkg::VW+1)'(mv_q);
    if (diff[ipid_pkg::VW] != diff[ipid_pkg::VW-1]) begin
      e_sat = diff[ipid_pkg::VW] ? {1'b1, {(ipid_pkg::VW-1){1'b0}}}
                                 : {1'b0, {(ipid_pkg::VW-1){1'b1}}};
    end else begin
      e_sat = diff[ipid_pkg::VW-1:0];
    end
  end

  // classified beat toward the back
  always_comb begin
    item_o.hold = !cfg_i.run_enable;
    item_o.e    = e_sat;
    item_o.e1   = e1_q;
    item_o.e2   = e2_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fr_valid_q <= 1'b0;
      e1_q       <= '0;
      e2_q       <= '0;
    end else begin
      fr_valid_q <= fr_valid_d;
      if (push_o && cfg_i.run_enable) begin
        e1_q <= e_sat;
        e2_q <= e1_q;
      end
    end
  end

  // input payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      sp_q <= setpoint_i;
      mv_q <= measured_value_i;
    end
  end

endmodule

[hdl/ipid_back.sv]
module ipid_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ipid_pkg::cfg_t    cfg_i,
  input  logic              q_empty_i,
  input  ipid_pkg::item_t   item_i,
  output logic              pop_o,
  output logic              m_tvalid_o,
  input  logic              m_tready_i,
  output logic signed [ipid_pkg::VW-1:0] drive_value_o
);

  localparam int VW = ipid_pkg::VW;
  localparam int BW = ipid_pkg::BW;
  localparam int PL = ipid_pkg::PL;
  localparam int PH = ipid_pkg::PH;
  localparam int MW = ipid_pkg::MW;
  localparam int QW = ipid_pkg::QW;
  localparam int TW = ipid_pkg::TW;
  localparam int SW = ipid_pkg::SW;
  localparam int NT = ipid_pkg::NTERM;
  localparam int NS = ipid_pkg::NSTAGE;

  function automatic logic [BW-1:0] absf(input logic signed [BW:0] v);
    return v[BW] ? BW'(-v) : BW'(v);
  endfunction

  logic                 adv;
  logic [NS-1:0]        vld_q, hold_q;

  // stage 1: differences
  logic signed [VW:0]   dp_q, dp_d;
  logic signed [VW+2:0] dd_q, dd_d;
  logic [VW-1:0]        abse_q, abse_d;
  logic                 esign_q;
  logic [VW-1:0]        ev;

  // stage 2: magnitudes and signs
  logic [VW-1:0]        mag_k_q [NT];
  logic [VW-1:0]        mag_k_d [NT];
  logic [BW-1:0]        mag_b_q [NT];
  logic [BW-1:0]        mag_b_d [NT];
  logic [NT-1:0]        neg2_q, neg2_d, neg3_q, neg4_q;
  logic                 int2_q, int3_q, int4_q, int5_q;

  // stage 3: partial products
  logic [VW+PL-1:0]     pp_lo_q [NT];
  logic [VW+PH-1:0]     pp_hi_q [NT];

  // stage 4: rounded products
  logic [QW-1:0]        rq_q [NT];
  logic [QW-1:0]        rq_d [NT];
  logic [MW:0]          full [NT];

  // stage 5: saturated, signed terms
  logic signed [TW-1:0] term_q [NT];
  logic signed [TW-1:0] term_d [NT];
  logic [TW-2:0]        rsat [NT];

  // stage 6: integral clamp
  logic signed [TW-1:0] tp_q, di_q, td_q, di_d;
  logic signed [TW-1:0] lim_ext, nlim_ext;
  logic signed [VW-1:0] lim_q, lim_d;
  logic signed [VW:0]   dlim, dadj;

  // stage 7 and 8: sum and step clamp
  logic signed [SW-1:0] sum_q, sum_d;
  logic signed [SW-1:0] step_ext;
  logic signed [VW-1:0] delta_q, delta_d;

  // output register and loop state
  logic                 out_valid_q;
  logic signed [VW-1:0] out_data_q;
  logic signed [VW-1:0] last_output_q;
  logic signed [VW:0]   y_sum;
  logic signed [VW-1:0] y_clamp;

  // the whole back moves one step when the output register can take a beat
  assign adv   = !out_valid_q || m_tready_i;
  assign pop_o = adv && !q_empty_i;

  // integral limit from the output limits, truncated toward zero
  always_comb begin
    dlim  = (VW+1)'(cfg_i.out_high) - (VW+1)'(cfg_i.out_low);
    dadj  = dlim + (dlim[VW] ? (VW+1)'(1) : (VW+1)'(0));
    lim_d = VW'(dadj >>> 1);
  end

  always_ff @(posedge clk_i) begin
    lim_q <= lim_d;
  end

  // stage 1
  always_comb begin
    ev     = item_i.e;
    dp_d   = (VW+1)'(item_i.e) - (VW+1)'(item_i.e1);
    dd_d   = (VW+3)'(item_i.e) + (VW+3)'(item_i.e2) - ((VW+3)'(item_i.e1) <<< 1);
    abse_d = ev[VW-1] ? VW'(~ev + VW'(1)) : ev;
  end

  // stage 2
  always_comb begin
    mag_k_d[ipid_pkg::TERM_P] = VW'(absf((BW+1)'(cfg_i.kp)));
    mag_k_d[ipid_pkg::TERM_I] = VW'(absf((BW+1)'(cfg_i.ki_dt)));
    mag_k_d[ipid_pkg::TERM_D] = VW'(absf((BW+1)'(cfg_i.kd_per_dt)));
    mag_b_d[ipid_pkg::TERM_P] = absf((BW+1)'(dp_q));
    mag_b_d[ipid_pkg::TERM_I] = BW'(abse_q);
    mag_b_d[ipid_pkg::TERM_D] = absf((BW+1)'(dd_q));
    neg2_d[ipid_pkg::TERM_P]  = cfg_i.kp[VW-1] ^ dp_q[VW];
    neg2_d[ipid_pkg::TERM_I]  = cfg_i.ki_dt[VW-1] ^ esign_q;
    neg2_d[ipid_pkg::TERM_D]  = cfg_i.kd_per_dt[VW-1] ^ dd_q[VW+2];
  end

  // stage 4: join partials and round half away from zero on the magnitude
  always_comb begin
    for (int i = 0; i < NT; i++) begin
      full[i] = ((MW+1)'(pp_hi_q[i]) << PL) + (MW+1)'(pp_lo_q[i])
              + ((MW+1)'(1) << (ipid_pkg::FB - 1));
      rq_d[i] = full[i][MW:ipid_pkg::FB];
    end
  end

  // stage 5: saturate and apply the sign
  always_comb begin
    for (int i = 0; i < NT; i++) begin
      rsat[i]   = (|rq_q[i][QW-1:TW-1]) ? {(TW-1){1'b1}} : rq_q[i][TW-2:0];
      term_d[i] = neg4_q[i] ? (TW'(0) - TW'(rsat[i])) : TW'(rsat[i]);
    end
  end

  // stage 6: integral separation and clamp
  always_comb begin
    lim_ext  = TW'(lim_q);
    nlim_ext = -lim_ext;
    di_d     = '0;
    if (int5_q) begin
      if (term_q[ipid_pkg::TERM_I] > lim_ext) begin
        di_d = lim_ext;
      end else if (term_q[ipid_pkg::TERM_I] < nlim_ext) begin
        di_d = nlim_ext;
      end else begin
        di_d = term_q[ipid_pkg::TERM_I];
      end
    end
  end

  // stage 7: summed increment
  assign sum_d = SW'(tp_q) + SW'(di_q) + SW'(td_q);

  // stage 8: step clamp
  always_comb begin
    step_ext = SW'($signed({1'b0, cfg_i.step_limit}));
    if (sum_q > step_ext) begin
      delta_d = VW'(step_ext);
    end else if (sum_q < -step_ext) begin
      delta_d = VW'(-step_ext);
    end else begin
      delta_d = VW'(sum_q);
    end
  end

  // output loop: add to the last output and clamp to the limits
  always_comb begin
    y_sum = (VW+1)'(last_output_q) + (VW+1)'(delta_q);
    if (y_sum > (VW+1)'(cfg_i.out_high)) begin
      y_clamp = cfg_i.out_high;
    end else if (y_sum < (VW+1)'(cfg_i.out_low)) begin
      y_clamp = cfg_i.out_low;
    end else begin
      y_clamp = VW'(y_sum);
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q         <= '0;
      hold_q        <= '0;
      out_valid_q   <= 1'b0;
      last_output_q <= '0;
    end else if (adv) begin
      vld_q       <= {vld_q[NS-2:0], pop_o};
      hold_q      <= {hold_q[NS-2:0], item_i.hold};
      out_valid_q <= vld_q[NS-1];
      if (vld_q[NS-1] && !hold_q[NS-1]) begin
        last_output_q <= y_clamp;
      end
    end
  end

  // pipeline payload
  always_ff @(posedge clk_i) begin
    if (adv) begin
      dp_q    <= dp_d;
      dd_q    <= dd_d;
      abse_q  <= abse_d;
      esign_q <= item_i.e[VW-1];
      int2_q  <= (abse_q < VW'(cfg_i.sep_thresh));
      int3_q  <= int2_q;
      int4_q  <= int3_q;
      int5_q  <= int4_q;
      neg2_q  <= neg2_d;
      neg3_q  <= neg2_q;
      neg4_q  <= neg3_q;
      for (int i = 0; i < NT; i++) begin
        mag_k_q[i] <= mag_k_d[i];
        mag_b_q[i] <= mag_b_d[i];
        pp_lo_q[i] <= (VW+PL)'(mag_k_q[i]) * (VW+PL)'(mag_b_q[i][PL-1:0]);
        pp_hi_q[i] <= (VW+PH)'(mag_k_q[i]) * (VW+PH)'(mag_b_q[i][BW-1:PL]);
        rq_q[i]    <= rq_d[i];
        term_q[i]  <= term_d[i];
      end
      tp_q    <= term_q[ipid_pkg::TERM_P];
      di_q    <= di_d;
      td_q    <= term_q[ipid_pkg::TERM_D];
      sum_q   <= sum_d;
      delta_q <= delta_d;
      if (vld_q[NS-1]) begin
        out_data_q <= hold_q[NS-1] ? last_output_q : y_clamp;
      end
    end
  end

  assign m_tvalid_o    = out_valid_q;
  assign drive_value_o = out_data_q;

  // a waiting result always equals the stored last output
  a_out_matches_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_data_q == last_output_q))
    else $error("output beat differs from last output state");

  // increment entering the output loop stays inside the step limit
  a_delta_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[NS-1] |-> (SW'(delta_q) <= step_ext && SW'(delta_q) >= -step_ext))
    else $error("increment beyond step limit");

  // a hold beat leaves the output state alone
  a_hold_keeps_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && vld_q[NS-1] && hold_q[NS-1]) |=> $stable(last_output_q))
    else $error("hold beat changed last output");

endmodule

[hdl/incremental_pid_controller_top.sv]
// channel | dir | handshake                  | payload
// s_axis  | in  | s_axis_tvalid/tready       | tdata: setpoint, measured_value
// m_axis  | out | m_axis_tvalid/tready       | tdata: drive_value
// cfg     | in  | cfg_valid_i/cfg_ready_o    | cfg_index_i, cfg_data_i
//
// one sample per cycle sustained while m_axis is ready
// the rate is set by the output loop: last output plus increment and clamp
// combinationally, with the products split into 17-bit slices over two stages
// reset loads default limits, zero gains and zero error and output state
// a stalled m_axis freezes the back pipeline; the four-entry queue keeps the
// front taking beats until it fills
module incremental_pid_controller_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [2*ipid_pkg::VW-1:0]         s_axis_tdata,  // setpoint, measured_value
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [ipid_pkg::VW-1:0]           m_axis_tdata,  // drive_value
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [ipid_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [ipid_pkg::VW-1:0]           cfg_data_i
);

  ipid_pkg::cfg_t    cfg_q;
  ipid_pkg::item_t   push_item, pop_item;
  ipid_pkg::q_stat_t q_stat;
  logic              push, pop;
  logic signed [ipid_pkg::VW-1:0] drive_value;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.kp         <= '0;
      cfg_q.ki_dt      <= '0;
      cfg_q.kd_per_dt  <= '0;
      cfg_q.out_low    <= {1'b1, {(ipid_pkg::VW-1){1'b0}}};
      cfg_q.out_high   <= {1'b0, {(ipid_pkg::VW-1){1'b1}}};
      cfg_q.sep_thresh <= '0;
      cfg_q.step_limit <= '1;
      cfg_q.run_enable <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (ipid_pkg::reg_idx_e'(cfg_index_i))
        ipid_pkg::REG_KP:         cfg_q.kp         <= cfg_data_i;
        ipid_pkg::REG_KI_DT:      cfg_q.ki_dt      <= cfg_data_i;
        ipid_pkg::REG_KD_PER_DT:  cfg_q.kd_per_dt  <= cfg_data_i;
        ipid_pkg::REG_OUT_LOW:    cfg_q.out_low    <= cfg_data_i;
        ipid_pkg::REG_OUT_HIGH:   cfg_q.out_high   <= cfg_data_i;
        ipid_pkg::REG_SEP_THRESH: cfg_q.sep_thresh <= cfg_data_i[ipid_pkg::VW-2:0];
        ipid_pkg::REG_STEP_LIMIT: cfg_q.step_limit <= cfg_data_i[ipid_pkg::VW-2:0];
        ipid_pkg::REG_RUN_ENABLE: cfg_q.run_enable <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  // front: input register, error and error history
  ipid_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .s_tvalid_i       (s_axis_tvalid),
    .s_tready_o       (s_axis_tready),
    .setpoint_i       (s_axis_tdata[ipid_pkg::VW-1:0]),
    .measured_value_i (s_axis_tdata[2*ipid_pkg::VW-1:ipid_pkg::VW]),
    .q_stat_i         (q_stat),
    .push_o           (push),
    .item_o           (push_item)
  );

  // queue between front and back
  ipid_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (push),
    .wr_item_i (push_item),
    .rd_en_i   (pop),
    .rd_item_o (pop_item),
    .stat_o    (q_stat)
  );

  // back: products, clamps and output loop
  ipid_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .q_empty_i     (q_stat.empty),
    .item_i        (pop_item),
    .pop_o         (pop),
    .m_tvalid_o    (m_axis_tvalid),
    .m_tready_i    (m_axis_tready),
    .drive_value_o (drive_value)
  );

  assign m_axis_tdata = drive_value;

endmodule

[sim/incremental_pid_controller_top_test.sv]
`timescale 1ns / 100ps

module incremental_pid_controller_top_test;
  import ipid_pkg::*;

  localparam int unsigned RUN_LIMIT     = 400000;
  localparam int          DRAIN_CYCLES  = 30;
  localparam int          SEGMENT_ITEMS = 116;
  localparam int          FIRST_UNMAPPED = int'(REG_RUN_ENABLE) + 1;
  localparam int          LAST_INDEX     = 2 ** CFG_IDX_W - 1;

  localparam logic [VW-1:0] V_MAX = {1'b0, {(VW-1){1'b1}}};
  localparam logic [VW-1:0] V_MIN = {1'b1, {(VW-1){1'b0}}};
  localparam logic [VW-1:0] Q_ONE = 1 << FB;
  localparam int            ONE_I = 1 << FB;

  localparam longint L_MAX  = (64'sd1 <<< (VW - 1)) - 1;
  localparam longint L_MIN  = -L_MAX - 1;
  localparam longint L_TERM = (64'sd1 <<< (VW + 1)) - 1;

  typedef enum {ROW_WRITE, ROW_SAMPLE} row_kind_e;
  typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;
  typedef enum {SET_MODEST, SET_EXTREME, SET_SWAPPED} setting_e;

  typedef struct {
    row_kind_e            kind;
    logic [CFG_IDX_W-1:0] index;
    logic [VW-1:0]        word;
    logic [VW-1:0]        setpoint;
    logic [VW-1:0]        measured;
    logic                 given;
    logic [VW-1:0]        drive;
  } plan_row_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [2*VW-1:0]      s_axis_tdata;  // setpoint, measured_value
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [VW-1:0]        m_axis_tdata;  // drive_value
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [VW-1:0]        cfg_data_i;

  // drive value typed into the plan, travels with the beat
  logic                 drive_given_valid;
  logic [VW-1:0]        drive_given;

  int                   gap_pct;
  int                   stall_pct;
  int                   mismatches;
  logic [VW-1:0]        drive_q[$];
  plan_row_t            opening_rows[$];

  // controller copy: registers
  longint gain_p     = 0;
  longint gain_i     = 0;
  longint gain_d     = 0;
  longint lim_lo     = L_MIN;
  longint lim_hi     = L_MAX;
  longint sep_window = 0;
  longint step_max   = L_MAX;
  logic   run_on     = 1'b0;

  // controller copy: history
  longint err_last   = 0;
  longint err_prev   = 0;
  longint drive_last = 0;

  incremental_pid_controller_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic longint clamp_to(longint x, longint lo, longint hi);
    return (x < lo) ? lo : ((x > hi) ? hi : x);
  endfunction

  // gain times difference, rounded half away from zero, saturated term
  function automatic longint scale_product(longint gain, longint diff);
    logic [127:0] mag;
    longint       ag, ad, r;
    logic         flip;
    flip = (gain < 0) != (diff < 0);
    ag   = (gain < 0) ? -gain : gain;
    ad   = (diff < 0) ? -diff : diff;
    mag  = ag;
    mag  = mag * ad;
    mag  = (mag + (128'd1 << (FB - 1))) >> FB;
    if (mag > L_TERM) r = L_TERM;
    else r = longint'(mag[63:0]);
    return flip ? -r : r;
  endfunction

  // one sample through the controller, history updated when running
  function automatic logic [VW-1:0] next_drive(logic [VW-1:0] sp_bits,
                                               logic [VW-1:0] mv_bits);
    logic signed [VW-1:0] sp_s, mv_s;
    longint               e, dp, di, dd, delta, half_span, mag_e, y;
    if (!run_on) return drive_last[VW-1:0];
    sp_s = sp_bits;
    mv_s = mv_bits;
    e    = clamp_to(longint'(sp_s) - longint'(mv_s), L_MIN, L_MAX);
    dp   = scale_product(gain_p, e - err_last);
    // integral only inside the separation window
    di    = 0;
    mag_e = (e < 0) ? -e : e;
    if (mag_e < sep_window) begin
      di        = scale_product(gain_i, e);
      half_span = (lim_hi - lim_lo) / 2;
      if (di > half_span) di = half_span;
      else if (di < -half_span) di = -half_span;
    end
    dd    = scale_product(gain_d, e - 2 * err_last + err_prev);
    delta = clamp_to(dp + di + dd, -step_max, step_max);
    // high limit is checked first: with swapped limits a sum above it gives the high limit, any other the low
    y = drive_last + delta;
    if (y > lim_hi) y = lim_hi;
    else if (y < lim_lo) y = lim_lo;
    err_prev   = err_last;
    err_last   = e;
    drive_last = y;
    return y[VW-1:0];
  endfunction

  function automatic void apply_register(logic [CFG_IDX_W-1:0] idx, logic [VW-1:0] data);
    logic signed [VW-1:0] sdata;
    sdata = data;
    case (idx)
      REG_KP:         gain_p     = sdata;
      REG_KI_DT:      gain_i     = sdata;
      REG_KD_PER_DT:  gain_d     = sdata;
      REG_OUT_LOW:    lim_lo     = sdata;
      REG_OUT_HIGH:   lim_hi     = sdata;
      REG_SEP_THRESH: sep_window = data[VW-2:0];
      REG_STEP_LIMIT: step_max   = data[VW-2:0];
      REG_RUN_ENABLE: run_on     = data[0];
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(string what);
    mismatches++;
    $display("%0t mismatch: %s", $time, what);
  endtask

  // watch all three channels at the rising edge: config first, then inputs, then results
  always @(posedge clk_i) begin : track_ports
    logic [VW-1:0] predicted;
    logic [VW-1:0] wanted;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) apply_register(cfg_index_i, cfg_data_i);
      if (s_axis_tvalid && s_axis_tready) begin
        predicted = next_drive(s_axis_tdata[VW-1:0], s_axis_tdata[2*VW-1:VW]);
        drive_q.push_back(drive_given_valid ? drive_given : predicted);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (drive_q.size() == 0) begin
          report_mismatch($sformatf("drive_value %h with no beat waiting", m_axis_tdata));
        end else begin
          wanted = drive_q.pop_front();
          if (m_axis_tdata !== wanted)
            report_mismatch($sformatf("drive_value got %h expected %h",
                                      m_axis_tdata, wanted));
        end
      end
    end
  end

  // receiver back-pressure
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    for (cycles = 0; cycles < RUN_LIMIT; cycles++) @(posedge clk_i);
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic void plan_write(logic [CFG_IDX_W-1:0] idx, logic [VW-1:0] data);
    plan_row_t row;
    row          = '{kind: ROW_WRITE, default: '0};
    row.kind     = ROW_WRITE;
    row.index    = idx;
    row.word     = data;
    opening_rows.push_back(row);
  endfunction

  function automatic void plan_sample(logic [VW-1:0] sp, logic [VW-1:0] mv,
                                      logic given = 1'b0, logic [VW-1:0] y = '0);
    plan_row_t row;
    row          = '{kind: ROW_SAMPLE, default: '0};
    row.kind     = ROW_SAMPLE;
    row.setpoint = sp;
    row.measured = mv;
    row.given    = given;
    row.drive    = y;
    opening_rows.push_back(row);
  endfunction

  function automatic logic [VW-1:0] any_word();
    case ($urandom_range(5))
      0:       return V_MIN;
      1:       return V_MAX;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [VW-1:0] modest_word(int unsigned span);
    int v;
    v = int'($urandom_range(2 * span)) - int'(span);
    return v;
  endfunction

  // hold off the sender until every result is back
  task automatic wait_drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (drive_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [VW-1:0] data);
    wait_drain();
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_sample(logic [VW-1:0] sp, logic [VW-1:0] mv,
                             logic given = 1'b0, logic [VW-1:0] y = '0);
    @(negedge clk_i);
    while ($urandom_range(99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid     <= 1'b1;
    s_axis_tdata      <= {mv, sp};
    drive_given_valid <= given;
    drive_given       <= y;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic load_setting(setting_e style);
    logic [VW-1:0] kp_w, ki_w, kd_w, lo_w, hi_w, sep_w, step_w;
    kp_w   = modest_word(4 * ONE_I);
    ki_w   = modest_word(ONE_I);
    kd_w   = modest_word(ONE_I / 2);
    lo_w   = -int'($urandom_range(1000 * ONE_I));
    hi_w   = $urandom_range(1000 * ONE_I);
    sep_w  = $urandom_range(100 * ONE_I);
    step_w = $urandom_range(200 * ONE_I, ONE_I);
    case (style)
      SET_EXTREME: begin
        kp_w   = any_word();
        ki_w   = any_word();
        kd_w   = any_word();
        lo_w   = $urandom_range(1) ? V_MIN : any_word();
        hi_w   = $urandom_range(1) ? V_MAX : any_word();
        sep_w  = any_word();
        step_w = any_word();
      end
      SET_SWAPPED: begin
        lo_w   = $urandom_range(1000 * ONE_I);
        hi_w   = -int'($urandom_range(1000 * ONE_I));
        step_w = any_word();
      end
      default: ;
    endcase
    write_register(REG_KP, kp_w);
    write_register(REG_KI_DT, ki_w);
    write_register(REG_KD_PER_DT, kd_w);
    write_register(REG_OUT_LOW, lo_w);
    write_register(REG_OUT_HIGH, hi_w);
    write_register(REG_SEP_THRESH, sep_w);
    write_register(REG_STEP_LIMIT, step_w);
    write_register(REG_RUN_ENABLE, VW'($urandom_range(5) != 0));
    // unmapped index must leave every register alone
    if ($urandom_range(2) == 0)
      write_register(CFG_IDX_W'($urandom_range(LAST_INDEX, FIRST_UNMAPPED)), $urandom);
  endtask

  initial begin : stimulus
    logic signed [VW-1:0] target, plant;
    int                   pick;
    s_axis_tvalid     = 1'b0;
    s_axis_tdata      = '0;
    cfg_valid_i       = 1'b0;
    cfg_index_i       = '0;
    cfg_data_i        = '0;
    drive_given_valid = 1'b0;
    drive_given       = '0;
    gap_pct           = 0;
    stall_pct         = 0;
    mismatches        = 0;
    target            = '0;
    plant             = '0;
    rst_ni            = 1'b0;

    // hold after reset returns the zero output
    plan_sample(V_MAX, V_MIN, 1'b1, '0);
    plan_sample(V_MIN, V_MAX, 1'b1, '0);
    // running with zero gains keeps the output at zero, error saturates
    plan_write(REG_RUN_ENABLE, 1);
    plan_sample(V_MAX, V_MIN, 1'b1, '0);
    plan_sample(V_MIN, V_MAX, 1'b1, '0);
    // proportional term, unit gain and both gain extremes
    plan_write(REG_KP, Q_ONE);
    plan_sample('0, '0);
    plan_sample(V_MIN, V_MAX);
    plan_write(REG_KP, V_MIN);
    plan_sample(V_MAX, V_MIN);
    plan_write(REG_KP, V_MAX);
    plan_sample(V_MIN, V_MAX);
    // rounding ties away from zero on a one-lsb gain
    plan_write(REG_KP, 1);
    plan_sample('0, '0);
    plan_sample(32'h0000_8000, '0);
    plan_sample('0, '0);
    plan_sample(32'h0000_7fff, '0);
    // integral window edges, high bit of the threshold dropped
    plan_write(REG_KP, '0);
    plan_write(REG_KI_DT, Q_ONE);
    plan_write(REG_SEP_THRESH, '1);
    plan_sample(Q_ONE, '0);
    plan_sample(V_MAX, '0);
    plan_sample(32'h7fff_fffe, '0);
    // integral clamped to half the output span
    plan_write(REG_KI_DT, V_MAX);
    plan_sample(32'h4000_0000, '0);
    // swapped limits give a negative integral bound
    plan_write(REG_OUT_LOW, Q_ONE * 100);
    plan_write(REG_OUT_HIGH, -(Q_ONE * 100));
    plan_sample(32'h0010_0000, '0);
    plan_sample(32'hfff0_0000, '0);
    // derivative term at the widest second difference
    plan_write(REG_KI_DT, '0);
    plan_write(REG_KD_PER_DT, Q_ONE);
    plan_write(REG_OUT_LOW, V_MIN);
    plan_write(REG_OUT_HIGH, V_MAX);
    plan_sample(V_MAX, V_MIN);
    plan_sample(V_MIN, V_MAX);
    plan_sample(V_MAX, V_MIN);
    // zero step limit freezes the output
    plan_write(REG_STEP_LIMIT, '0);
    plan_sample(V_MIN, '0);
    plan_write(REG_STEP_LIMIT, '1);
    plan_write(CFG_IDX_W'(LAST_INDEX), '1);
    // equal limits pin the output, hold then repeats it
    plan_write(REG_OUT_LOW, Q_ONE * 5);
    plan_write(REG_OUT_HIGH, Q_ONE * 5);
    plan_sample(32'h1234_5678, '0, 1'b1, Q_ONE * 5);
    plan_write(REG_RUN_ENABLE, '0);
    plan_sample(V_MIN, V_MAX, 1'b1, Q_ONE * 5);
    plan_sample(V_MAX, V_MIN, 1'b1, Q_ONE * 5);

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (opening_rows[i]) begin
      if (opening_rows[i].kind == ROW_WRITE)
        write_register(opening_rows[i].index, opening_rows[i].word);
      else
        send_sample(opening_rows[i].setpoint, opening_rows[i].measured,
                    opening_rows[i].given, opening_rows[i].drive);
    end

    // random part: idle modes times register settings
    for (int p = 0; p < 4; p++) begin
      case (idle_mode_e'(p))
        IDLE_NONE:     begin gap_pct = 0;  stall_pct = 0;  end
        IDLE_SENDER:   begin gap_pct = 77; stall_pct = 0;  end
        IDLE_RECEIVER: begin gap_pct = 0;  stall_pct = 77; end
        default:       begin gap_pct = 12; stall_pct = 12; end
      endcase
      for (int s = 0; s < 2; s++) begin
        load_setting(setting_e'((2 * p + s) % 3));
        target = modest_word(500 * ONE_I);
        plant  = modest_word(500 * ONE_I);
        for (int n = 0; n < SEGMENT_ITEMS; n++) begin
          pick = $urandom_range(99);
          if (pick == 0) wait_drain();
          if (pick < 65) begin
            // plant following a setpoint that steps now and then
            if ($urandom_range(19) == 0) target = modest_word(500 * ONE_I);
            plant = plant + ((target - plant) >>> 3) + $signed(modest_word(ONE_I));
            send_sample(target, plant);
          end else if (pick < 88) begin
            send_sample($urandom, $urandom);
          end else begin
            send_sample(any_word(), any_word());
          end
        end
      end
    end

    wait_drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
